### rtl/cbfd_pkg.sv
// constants, types and state codes shared by the bar drawer modules
// no dependencies; imported by every module of the block but the frame ram
`default_nettype none

package cbfd_pkg;

    // display geometry
    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = PAGE_COUNT * DISPLAY_WIDTH;
    localparam int CX             = DISPLAY_WIDTH / 2;

    // index widths
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(DISPLAY_WIDTH);
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int READ_ADDR_W = 10;
    localparam int DATA_W      = 8;

    // signed pixel coordinates, wide enough for top + height and cx +/- half
    localparam int COORD_W = 10;

    // fill arithmetic: fill = trunc(pct * half / 100)
    localparam int PCT_MAX     = 100;
    localparam int FILL_W      = 7;
    localparam int PROD_W      = 2 * FILL_W;
    localparam int RECIP_W     = 13;
    localparam int RPROD_W     = PROD_W + RECIP_W;
    localparam int RECIP_100   = 5243;   // ceil(2^19 / 100), exact for products up to 12700
    localparam int RECIP_SHIFT = 19;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_FILL,
        S_DRAW,
        S_DRAIN,
        S_READ,
        S_DONE
    } t_state;

    // bar geometry, registered once per draw
    typedef struct packed {
        t_coord top;       // top outline row
        t_coord bot;       // bottom outline row
        t_coord int_top;   // first interior row
        t_coord int_bot;   // last interior row
        t_coord col_lo;    // left outline column, first interior column
        t_coord col_r;     // right outline column, last interior column
        t_coord row_end;   // last column of the outline rows
        t_coord fill_l;    // lowest lit column on the left side
        t_coord fill_r;    // first unlit column on the right side
        logic   fill_neg;
        logic   fill_pos;
    } t_bar_geom;

endpackage

`default_nettype wire

### rtl/cbfd_frame_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module cbfd_frame_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/cbfd_fill_calc.sv
// two-stage fill computation: clamp and scale, then divide by 100 by reciprocal
// depends on cbfd_pkg
`default_nettype none

module cbfd_fill_calc (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic signed [7:0]          i_fill_percent,
    input  wire logic        [6:0]          i_half_width,
    output logic                            o_done,
    output logic [cbfd_pkg::FILL_W-1:0]     o_fill_mag,
    output logic                            o_fill_neg
);
    import cbfd_pkg::*;

    logic [7:0]         abs_pct;
    logic [FILL_W-1:0]  mag;
    logic [PROD_W-1:0]  n_prod;
    logic [PROD_W-1:0]  r_prod;
    logic [RPROD_W-1:0] scaled;
    logic               r_v1;
    logic               r_v2;
    logic               r_neg1;
    logic               r_neg2;
    logic [FILL_W-1:0]  r_q;

    // stage 1: |pct| clamped to 100, times half width
    always_comb begin
        abs_pct = i_fill_percent[7] ? 8'(-i_fill_percent) : 8'(i_fill_percent);
        mag     = (abs_pct > 8'(PCT_MAX)) ? FILL_W'(PCT_MAX) : abs_pct[FILL_W-1:0];
        n_prod  = PROD_W'(mag) * PROD_W'(i_half_width);
    end

    // stage 2: divide by 100
    assign scaled = RPROD_W'(r_prod) * RPROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_neg1 <= i_fill_percent[7];
        r_q    <= scaled[RECIP_SHIFT +: FILL_W];
        r_neg2 <= r_neg1;
    end

    assign o_done     = r_v2;
    assign o_fill_mag = r_q;
    assign o_fill_neg = r_neg2;

endmodule

`default_nettype wire

### rtl/cbfd_byte_merge.sv
// merges the bar outline and interior into one page byte of one column
// depends on cbfd_pkg
`default_nettype none

module cbfd_byte_merge (
    input  wire cbfd_pkg::t_bar_geom          i_geom,
    input  wire logic [cbfd_pkg::COL_W-1:0]   i_col,
    input  wire logic [cbfd_pkg::PAGE_W-1:0]  i_page,
    input  wire logic [cbfd_pkg::DATA_W-1:0]  i_byte,
    output logic      [cbfd_pkg::DATA_W-1:0]  o_byte
);
    import cbfd_pkg::*;

    t_coord col;
    t_coord row;
    logic   in_col_int;
    logic   in_row_span_col;
    logic   on_edge_col;
    logic   lit_int;
    logic   on_screen;
    logic   in_row_int;
    logic   edge_row;
    logic   in_row_span;

    always_comb begin
        col             = t_coord'(i_col);
        in_col_int      = (col >= i_geom.col_lo) && (col <= i_geom.col_r);
        in_row_span_col = (col >= i_geom.col_lo) && (col <= i_geom.row_end);
        on_edge_col     = (col == i_geom.col_lo) || (col == i_geom.col_r);
        // left half fills outward from cx-1, right half from cx
        if (col < t_coord'(CX)) begin
            lit_int = i_geom.fill_neg && (col >= i_geom.fill_l);
        end else begin
            lit_int = i_geom.fill_pos && (col < i_geom.fill_r);
        end
        row         = '0;
        on_screen   = 1'b0;
        in_row_int  = 1'b0;
        edge_row    = 1'b0;
        in_row_span = 1'b0;
        o_byte      = i_byte;
        for (int b = 0; b < DATA_W; b++) begin
            row         = t_coord'({i_page, 3'(b)});
            on_screen   = row < t_coord'(DISPLAY_HEIGHT);
            in_row_int  = (row >= i_geom.int_top) && (row <= i_geom.int_bot);
            edge_row    = (row == i_geom.top) || (row == i_geom.bot);
            in_row_span = (row >= i_geom.top) && (row <= i_geom.bot);
            if (on_screen) begin
                // interior is checked first, so it wins over the outline
                if (in_col_int && in_row_int) begin
                    o_byte[b] = lit_int;
                end else if ((in_row_span_col && edge_row) ||
                             (on_edge_col && in_row_span)) begin
                    o_byte[b] = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/centered_bar_framebuffer_drawer.sv
// top level: sequencer, framebuffer ram, fill unit and byte merge
// depends on cbfd_pkg, cbfd_frame_ram, cbfd_fill_calc, cbfd_byte_merge
`default_nettype none

//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_ready   | i_op, i_bar_top, i_bar_width, i_bar_height,
//           |                           | i_fill_percent, i_read_addr
//  out      | o_out_valid / i_out_ready | o_read_data
//
//  one item at a time; clear zeroes every byte (one ram write a cycle), draw runs
//  the fill unit, then one read-modify-write per byte through the single write port;
//  read passes through S_READ and S_DONE, the unused op through S_DONE only
//  after reset a clearing pass over all STORE_BYTES bytes (1024) runs with o_in_ready low
//  the result sits in an output register; the next item is taken while it waits,
//  and only a finished item whose result cannot be placed holds the sequencer

module centered_bar_framebuffer_drawer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_op,
    input  wire logic signed [7:0]                 i_bar_top,
    input  wire logic [7:0]                        i_bar_width,
    input  wire logic [7:0]                        i_bar_height,
    input  wire logic signed [7:0]                 i_fill_percent,
    input  wire logic [cbfd_pkg::READ_ADDR_W-1:0]  i_read_addr,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [cbfd_pkg::DATA_W-1:0]            o_read_data
);
    import cbfd_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(DISPLAY_WIDTH - 1);

    t_state r_state, n_state;

    // sweep counters: address plus its column and page
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [PAGE_W-1:0] r_page, n_page;

    // pending write of the draw read-modify-write
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    logic [COL_W-1:0]  r_pend_col;
    logic [PAGE_W-1:0] r_pend_page;

    // captured item fields
    logic signed [7:0] r_bar_top, n_bar_top;
    logic [7:0]        r_bar_width, n_bar_width;
    logic [7:0]        r_bar_height, n_bar_height;
    logic              r_in_range, n_in_range;

    t_bar_geom r_geom, n_geom, calc_geom;

    logic [DATA_W-1:0] r_result, n_result;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_read_data, n_read_data;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] merged;

    // fill unit
    logic              fill_start;
    logic              fill_done;
    logic [FILL_W-1:0] fill_mag;
    logic              fill_neg;

    cbfd_frame_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (ADDR_W),
        .DW    (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cbfd_fill_calc u_fill (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (fill_start),
        .i_fill_percent (i_fill_percent),
        .i_half_width   (i_bar_width[7:1]),
        .o_done         (fill_done),
        .o_fill_mag     (fill_mag),
        .o_fill_neg     (fill_neg)
    );

    cbfd_byte_merge u_merge (
        .i_geom (r_geom),
        .i_col  (r_pend_col),
        .i_page (r_pend_page),
        .i_byte (ram_rdata),
        .o_byte (merged)
    );

    // bar geometry from the captured fields and the fill level
    always_comb begin
        t_coord half;
        t_coord height;
        half               = t_coord'(r_bar_width[7:1]);
        height             = t_coord'(r_bar_height);
        calc_geom.top      = t_coord'(r_bar_top);
        calc_geom.bot      = t_coord'(r_bar_top) + height - t_coord'(1);
        calc_geom.int_top  = t_coord'(r_bar_top) + t_coord'(1);
        calc_geom.int_bot  = t_coord'(r_bar_top) + height - t_coord'(2);
        calc_geom.col_lo   = t_coord'(CX) - half;
        calc_geom.col_r    = t_coord'(CX) + half - t_coord'(1);
        calc_geom.row_end  = t_coord'(CX) - half + t_coord'(r_bar_width) - t_coord'(1);
        calc_geom.fill_l   = t_coord'(CX) - t_coord'(1) - t_coord'(fill_mag);
        calc_geom.fill_r   = t_coord'(CX) + t_coord'(fill_mag);
        calc_geom.fill_neg = fill_neg && (fill_mag != '0);
        calc_geom.fill_pos = !fill_neg && (fill_mag != '0);
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_col        = r_col;
        n_page       = r_page;
        n_bar_top    = r_bar_top;
        n_bar_width  = r_bar_width;
        n_bar_height = r_bar_height;
        n_in_range   = r_in_range;
        n_geom       = r_geom;
        n_result     = r_result;
        n_out_valid  = r_out_valid;
        n_read_data  = r_read_data;
        n_pend       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = '0;
        ram_raddr    = r_addr;
        fill_start   = 1'b0;
        o_in_ready   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT, S_CLEAR: begin
                // zero one byte a cycle
                ram_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                ram_raddr  = ADDR_W'(i_read_addr);
                if (i_in_valid) begin
                    n_bar_top    = i_bar_top;
                    n_bar_width  = i_bar_width;
                    n_bar_height = i_bar_height;
                    n_in_range   = 32'(i_read_addr) < 32'(STORE_BYTES);
                    n_addr       = '0;
                    n_col        = '0;
                    n_page       = '0;
                    n_result     = '0;
                    case (t_op'(i_op))
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_DRAW: begin
                            fill_start = 1'b1;
                            n_state    = S_FILL;
                        end
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_FILL: begin
                if (fill_done) begin
                    n_geom  = calc_geom;
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                // issue a read; its write-back follows in the next cycle
                n_pend = 1'b1;
                if (r_col == LAST_COL) begin
                    n_col  = '0;
                    n_page = r_page + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_READ: begin
                n_result = r_in_range ? ram_rdata : '0;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // place the result once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_read_data = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_pend_addr;
            ram_wdata = merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_col       <= '0;
            r_page      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_col       <= n_col;
            r_page      <= n_page;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr  <= r_addr;
        r_pend_col   <= r_col;
        r_pend_page  <= r_page;
        r_bar_top    <= n_bar_top;
        r_bar_width  <= n_bar_width;
        r_bar_height <= n_bar_height;
        r_in_range   <= n_in_range;
        r_geom       <= n_geom;
        r_result     <= n_result;
        r_read_data  <= n_read_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

    // the store never changes while waiting for an item
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("framebuffer written while idle");

    // the read in flight is always one byte ahead of the write-back
    a_rmw_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_state == S_DRAW) |-> (r_addr == r_pend_addr + 1'b1))
        else $error("draw read overlaps its pending write-back");

    // no item is taken while a write-back is pending
    a_ready_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend)
        else $error("item accepted during a draw write-back");

    // the clearing pass only ends after the last byte
    a_init_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_INIT && r_state != S_INIT) |-> ($past(r_addr) == LAST_ADDR))
        else $error("clearing pass ended early");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking bench for centered_bar_framebuffer_drawer: a framebuffer model
// predicts every read byte and a small scoreboard class checks each result item
// depends on cbfd_pkg and the rtl of the block
`default_nettype none

module tb_top;

    import cbfd_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int ITEM_COUNT     = 290;
    localparam int HOLD_CYCLES    = 300;
    // longest quiet stretch: clearing pass or one draw, plus stalls, several times over
    localparam int WATCHDOG_LIMIT = 20000;
    // a draw is the slowest item, so wait that long for anything unexpected
    localparam int TAIL_CYCLES    = STORE_BYTES + 16;

    // framebuffer model plus the queue of bytes the block still owes us
    class frame_checker;
        byte unsigned frame_bytes [STORE_BYTES];
        logic [7:0]   owed_bytes [$];
        int           owed_item_no [$];
        int           mismatches;
        int           bytes_checked;
        int           items_noted;
        int           draws;
        int           clears;
        int           reads;
        int           nops;

        function new();
            foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
        endfunction

        function void put_pixel(int col, int row, bit lit);
            int idx;
            if (col < 0 || col >= DISPLAY_WIDTH || row < 0 || row >= DISPLAY_HEIGHT)
                return;
            idx = (row >> 3) * DISPLAY_WIDTH + col;
            if (lit)
                frame_bytes[idx] = frame_bytes[idx] | (8'h01 << (row & 7));
            else
                frame_bytes[idx] = frame_bytes[idx] & ~(8'h01 << (row & 7));
        endfunction

        function void draw_bar(int top, int width, int height, int pct);
            int  half;
            int  fill;
            bit  left_on;
            bit  right_on;
            if (pct < -PCT_MAX) pct = -PCT_MAX;
            if (pct > PCT_MAX) pct = PCT_MAX;
            half = width / 2;
            // outline rows, then outline columns
            for (int i = 0; i < width; i++) begin
                put_pixel(CX - half + i, top, 1'b1);
                put_pixel(CX - half + i, top + height - 1, 1'b1);
            end
            for (int j = 0; j < height; j++) begin
                put_pixel(CX - half, top + j, 1'b1);
                put_pixel(CX + half - 1, top + j, 1'b1);
            end
            // integer division truncates toward zero, as the block does
            fill = (pct * half) / PCT_MAX;
            for (int i = 0; i < half; i++) begin
                left_on  = (fill < 0) && (i <= -fill);
                right_on = (fill > 0) && (i < fill);
                for (int j = 1; j < height - 1; j++) begin
                    put_pixel(CX - 1 - i, top + j, left_on);
                    put_pixel(CX + i, top + j, right_on);
                end
            end
        endfunction

        function void note_item(t_op op, logic signed [7:0] top, logic [7:0] width,
                                logic [7:0] height, logic signed [7:0] pct,
                                logic [READ_ADDR_W-1:0] addr);
            logic [7:0] byte_out;
            byte_out = 8'h00;
            case (op)
                OP_CLEAR: begin
                    foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
                    clears++;
                end
                OP_DRAW: begin
                    draw_bar(int'(top), int'(width), int'(height), int'(pct));
                    draws++;
                end
                OP_READ: begin
                    if (int'(addr) < STORE_BYTES) byte_out = frame_bytes[addr];
                    reads++;
                end
                default: nops++;
            endcase
            owed_bytes.push_back(byte_out);
            owed_item_no.push_back(items_noted);
            items_noted++;
        endfunction

        task report_mismatch(string what);
            $display("tb_top: mismatch: %s", what);
            mismatches++;
        endtask

        task check_byte(logic [7:0] got);
            logic [7:0] want;
            int         item_no;
            if (owed_bytes.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with no item outstanding", got));
                return;
            end
            want    = owed_bytes.pop_front();
            item_no = owed_item_no.pop_front();
            bytes_checked++;
            if (got !== want)
                report_mismatch($sformatf("item %0d read_data 0x%02h, expected 0x%02h",
                                          item_no, got, want));
        endtask

        function int outstanding();
            return owed_bytes.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   out_ready = 1'b0;
    logic [1:0]             op_r = OP_NONE;
    logic signed [7:0]      top_r = '0;
    logic [7:0]             width_r = '0;
    logic [7:0]             height_r = '0;
    logic signed [7:0]      pct_r = '0;
    logic [READ_ADDR_W-1:0] addr_r = '0;
    wire                    in_ready;
    wire                    out_valid;
    wire [DATA_W-1:0]       read_data;

    frame_checker sb = new();

    // idling rates in percent, changed per phase by the stimulus
    int  send_idle_pct = 12;
    int  recv_idle_pct = 50;
    bit  hold_req = 1'b0;
    int  quiet_cycles = 0;

    centered_bar_framebuffer_drawer dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (op_r),
        .i_bar_top      (top_r),
        .i_bar_width    (width_r),
        .i_bar_height   (height_r),
        .i_fill_percent (pct_r),
        .i_read_addr    (addr_r),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_read_data    (read_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // offer one item, holding valid and payload until it is taken;
    // valid is left high afterwards so back-to-back items never toggle it
    task automatic send_item(t_op op, logic signed [7:0] top, logic [7:0] width,
                             logic [7:0] height, logic signed [7:0] pct,
                             logic [READ_ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        op_r     <= op;
        top_r    <= top;
        width_r  <= width;
        height_r <= height;
        pct_r    <= pct;
        addr_r   <= addr;
        do @(posedge i_clk); while (!in_ready);
        sb.note_item(op, top, width, height, pct, addr);
    endtask

    // the unused fields of reads and draws carry noise; the block must ignore them
    task automatic send_read(logic [READ_ADDR_W-1:0] addr);
        send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), addr);
    endtask

    task automatic send_draw(logic signed [7:0] top, logic [7:0] width,
                             logic [7:0] height, logic signed [7:0] pct);
        send_item(OP_DRAW, top, width, height, pct, READ_ADDR_W'($urandom));
    endtask

    // an address inside or just around the box a bar covers
    function automatic logic [READ_ADDR_W-1:0] addr_near(int top, int width, int height);
        int row;
        int col;
        row = top - 1 + $urandom_range(0, height + 1);
        col = CX - width / 2 - 1 + $urandom_range(0, width + 1);
        if (row < 0) row = 0;
        if (row >= DISPLAY_HEIGHT) row = DISPLAY_HEIGHT - 1;
        if (col < 0) col = 0;
        if (col >= DISPLAY_WIDTH) col = DISPLAY_WIDTH - 1;
        return READ_ADDR_W'((row >> 3) * DISPLAY_WIDTH + col);
    endfunction

    // a draw followed by reads probing its box; mostly on-screen sizes,
    // now and then fully random fields
    task automatic draw_and_probe();
        logic signed [7:0] top;
        logic [7:0]        width;
        logic [7:0]        height;
        if ($urandom_range(0, 9) == 0) begin
            top    = 8'($urandom);
            width  = 8'($urandom);
            height = 8'($urandom);
        end else begin
            top    = 8'($urandom_range(0, 80) - 10);
            width  = 8'($urandom_range(0, 130));
            height = 8'($urandom_range(0, 40));
        end
        send_draw(top, width, height, 8'($urandom));
        repeat ($urandom_range(4, 8))
            send_read(addr_near(int'(top), int'(width), int'(height)));
    endtask

    // result side: check every accepted result item
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_byte(read_data);
    end

    // result side: ready with random stalls, and one long hold-off on request
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: timeout, no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int pick;
        bit hold_done;
        hold_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: fresh store, unused op, extremes of every field
        send_read(READ_ADDR_W'(0));
        send_read(READ_ADDR_W'(STORE_BYTES - 1));
        send_item(OP_NONE, 8'sh80, 8'hff, 8'hff, 8'sh7f, 10'h3ff);
        send_draw(8'sd10, 8'd40, 8'd12, 8'sd50);
        send_read(READ_ADDR_W'(1 * DISPLAY_WIDTH + 64));
        send_read(READ_ADDR_W'(1 * DISPLAY_WIDTH + 44));
        send_read(READ_ADDR_W'(2 * DISPLAY_WIDTH + 83));
        send_draw(8'sd30, 8'd60, 8'd20, -8'sd60);
        send_read(READ_ADDR_W'(3 * DISPLAY_WIDTH + 40));
        send_read(READ_ADDR_W'(4 * DISPLAY_WIDTH + 63));
        send_read(READ_ADDR_W'(6 * DISPLAY_WIDTH + 93));
        // widest, tallest, top far above the screen, fill clamped high
        send_draw(8'sh80, 8'hff, 8'hff, 8'sh7f);
        send_read(READ_ADDR_W'(64));
        send_read(READ_ADDR_W'(7 * DISPLAY_WIDTH + 127));
        // full-screen bar, fill clamped low
        send_draw(8'sd0, 8'hff, 8'd64, 8'sh80);
        send_read(READ_ADDR_W'(3 * DISPLAY_WIDTH + 0));
        send_read(READ_ADDR_W'(3 * DISPLAY_WIDTH + 64));
        // zero width with a single row, then zero height (bottom row above top)
        send_draw(8'sd5, 8'd0, 8'd1, 8'sd0);
        send_draw(8'sd20, 8'd7, 8'd0, 8'sd99);
        send_read(READ_ADDR_W'(CX - 1));
        send_read(READ_ADDR_W'(2 * DISPLAY_WIDTH + CX));
        send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  READ_ADDR_W'($urandom));
        send_read(READ_ADDR_W'(2 * DISPLAY_WIDTH + CX));

        // random part in three idling phases
        while (sb.items_noted < ITEM_COUNT) begin
            if (sb.items_noted >= ITEM_COUNT / 3 && sb.items_noted < 2 * ITEM_COUNT / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 12;
            end else if (sb.items_noted >= 2 * ITEM_COUNT / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!hold_done) begin
                    // long receiver hold-off while reads keep coming
                    hold_done = 1'b1;
                    hold_req  = 1'b1;
                    repeat (12) send_read(READ_ADDR_W'($urandom));
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 12)
                draw_and_probe();
            else if (pick < 15)
                send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          READ_ADDR_W'($urandom));
            else if (pick < 18)
                send_item(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          READ_ADDR_W'($urandom));
            else
                send_read(READ_ADDR_W'($urandom));
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d items: %0d draws, %0d clears, %0d reads, %0d unused-op",
                 sb.items_noted, sb.draws, sb.clears, sb.reads, sb.nops);
        $display("tb_top: %0d result items checked, %0d mismatches",
                 sb.bytes_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
